// ===== rtl/sfia_pkg.sv =====
package sfia_pkg;

   localparam int unsigned DATA_W    = 32;
   localparam int unsigned GAIN_W    = 16;
   localparam int unsigned ROW_W     = 64;
   localparam int unsigned TR_W      = 16;
   localparam int unsigned DRIVE_W   = 31;
   localparam int unsigned DT_W      = 16;
   localparam int unsigned SUM_W     = 48;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned NLANE     = 2;

   localparam logic [ROW_W-1:0]   GAINS_RESET   = '0;
   localparam logic [TR_W-1:0]    INV_TR_RESET  = 16'd256;
   localparam logic [DRIVE_W-1:0] DRIVE_RESET   = 31'd65536;
   localparam logic [DT_W-1:0]    STEP_DT_RESET = 16'd66;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAINS_PITCH = 3'd0,
      CSR_GAINS_YAW   = 3'd1,
      CSR_INT_GAINS   = 3'd2,
      CSR_INV_TR_P    = 3'd3,
      CSR_INV_TR_Y    = 3'd4,
      CSR_MAX_DRIVE   = 3'd5,
      CSR_STEP_DT     = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_HOLD
   } state_type;

   // lane schedule, one multiply issued per step at most
   typedef enum logic [3:0] {
      PH_PROP0  = 4'd0,
      PH_PROP1  = 4'd1,
      PH_PROP2  = 4'd2,
      PH_PROP3  = 4'd3,
      PH_INT0   = 4'd4,
      PH_INT1   = 4'd5,
      PH_INT2   = 4'd6,
      PH_ERR    = 4'd7,
      PH_DT     = 4'd8,
      PH_SUM    = 4'd9,
      PH_CLAMP  = 4'd10,
      PH_EXCESS = 4'd11,
      PH_TR     = 4'd12,
      PH_WIND   = 4'd13
   } phase_type;

   typedef struct packed {
      logic      run;
      phase_type phase;
   } lane_ctl_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] pitch_error;
      logic signed [DATA_W-1:0] yaw_error;
      logic signed [DATA_W-1:0] pitch_rate;
      logic signed [DATA_W-1:0] yaw_rate;
   } sample_type;

endpackage

// ===== rtl/sfia_if.sv =====
interface sfia_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pitch_error;
   logic signed [31:0] yaw_error;
   logic signed [31:0] pitch_rate;
   logic signed [31:0] yaw_rate;

   modport source (output valid, pitch_error, yaw_error, pitch_rate, yaw_rate,
                   input ready);
   modport sink   (input valid, pitch_error, yaw_error, pitch_rate, yaw_rate,
                   output ready);
endinterface

interface sfia_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] prop_pitch;
   logic signed [31:0] prop_yaw;
   logic signed [31:0] integ_pitch;
   logic signed [31:0] integ_yaw;

   modport source (output valid, prop_pitch, prop_yaw, integ_pitch, integ_yaw,
                   input ready);
   modport sink   (input valid, prop_pitch, prop_yaw, integ_pitch, integ_yaw,
                   output ready);
endinterface

// ===== rtl/sfia_lane.sv =====
module sfia_lane
   import sfia_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  lane_ctl_type              ctl,
   input  sample_type                x,
   input  logic [ROW_W-1:0]          row_gains,
   input  logic [2*GAIN_W-1:0]       int_gains,
   input  logic [TR_W-1:0]           inv_tr,
   input  logic [DRIVE_W-1:0]        max_drive,
   input  logic [DT_W-1:0]           step_dt,
   output logic signed [DATA_W-1:0]  prop,
   output logic signed [DATA_W-1:0]  integ
);

   localparam int unsigned OPND_W = 42;
   localparam int unsigned MB_W   = 17;
   localparam int unsigned PROD_W = OPND_W + MB_W;
   localparam int unsigned ACCP_W = 50;
   localparam int unsigned ACCI_W = 49;
   localparam int unsigned INC_W  = 43;

   localparam logic signed [SUM_W-1:0]  SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0]  SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic signed [OPND_W-1:0] EXC_MAX = {1'b0, {(OPND_W-1){1'b1}}};
   localparam logic signed [OPND_W-1:0] EXC_MIN = {1'b1, {(OPND_W-1){1'b0}}};
   localparam logic signed [DATA_W-1:0] D_MAX   = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] D_MIN   = {1'b1, {(DATA_W-1){1'b0}}};

   logic signed [OPND_W-1:0] mul_a;
   logic signed [MB_W-1:0]   mul_b;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACCP_W-1:0] acc_p_ff, acc_p_in;
   logic signed [ACCI_W-1:0] acc_i_ff, acc_i_in;
   logic signed [OPND_W-1:0] opnd_ff, opnd_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic signed [DATA_W-1:0] wind_ff, wind_in;
   logic signed [DATA_W-1:0] u_ff, u_in;

   logic signed [ACCP_W-1:0] prop_sh;
   logic signed [INC_W-1:0]  inc;
   logic signed [SUM_W:0]    sum_raw;
   logic signed [SUM_W:0]    excess_raw;
   logic signed [PROD_W-1:0] wind_sh;
   logic signed [DATA_W-1:0] lim, neg_lim;

   // multiplier operand select
   always_comb begin
      case (ctl.phase)
         PH_PROP0: begin
            mul_a = OPND_W'(x.pitch_error);
            mul_b = MB_W'($signed(row_gains[15:0]));
         end
         PH_PROP1: begin
            mul_a = OPND_W'(x.yaw_error);
            mul_b = MB_W'($signed(row_gains[31:16]));
         end
         PH_PROP2: begin
            mul_a = OPND_W'(x.pitch_rate);
            mul_b = MB_W'($signed(row_gains[47:32]));
         end
         PH_PROP3: begin
            mul_a = OPND_W'(x.yaw_rate);
            mul_b = MB_W'($signed(row_gains[63:48]));
         end
         PH_INT0: begin
            mul_a = OPND_W'(x.pitch_error);
            mul_b = MB_W'($signed(int_gains[15:0]));
         end
         PH_INT1: begin
            mul_a = OPND_W'(x.yaw_error);
            mul_b = MB_W'($signed(int_gains[31:16]));
         end
         PH_TR: begin
            mul_a = opnd_ff;
            mul_b = $signed({1'b0, inv_tr});
         end
         default: begin
            mul_a = opnd_ff;
            mul_b = $signed({1'b0, step_dt});
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   assign lim     = $signed({1'b0, max_drive});
   assign neg_lim = -lim;
   assign inc        = INC_W'(prod_ff >>> 16);
   assign sum_raw    = (SUM_W+1)'(sum_ff) + (SUM_W+1)'(inc);
   assign excess_raw = (SUM_W+1)'(u_ff) - (SUM_W+1)'(sum_ff);
   assign wind_sh    = prod_ff >>> 8;
   assign prop_sh    = acc_p_ff >>> 8;

   always_comb begin
      acc_p_in = acc_p_ff;
      acc_i_in = acc_i_ff;
      opnd_in  = opnd_ff;
      sum_in   = sum_ff;
      wind_in  = wind_ff;
      u_in     = u_ff;
      if (ctl.run) begin
         case (ctl.phase)
            PH_PROP1: acc_p_in = prod_ff[ACCP_W-1:0];
            PH_PROP2: acc_p_in = acc_p_ff + prod_ff[ACCP_W-1:0];
            PH_PROP3, PH_INT0: acc_p_in = acc_p_ff - prod_ff[ACCP_W-1:0];
            PH_INT1: acc_i_in = prod_ff[ACCI_W-1:0];
            PH_INT2: acc_i_in = acc_i_ff + prod_ff[ACCI_W-1:0];
            PH_ERR: opnd_in = OPND_W'(acc_i_ff >>> 8) + OPND_W'(wind_ff);
            PH_SUM: begin
               if (sum_raw[SUM_W] != sum_raw[SUM_W-1])
                  sum_in = sum_raw[SUM_W] ? SUM_MIN : SUM_MAX;
               else
                  sum_in = sum_raw[SUM_W-1:0];
            end
            PH_CLAMP: begin
               if (sum_ff > SUM_W'(lim))
                  u_in = lim;
               else if (sum_ff < SUM_W'(neg_lim))
                  u_in = neg_lim;
               else
                  u_in = sum_ff[DATA_W-1:0];
            end
            PH_EXCESS: begin
               // past this range the windup term saturates anyway
               if (excess_raw[SUM_W:OPND_W-1] != {(SUM_W-OPND_W+2){excess_raw[SUM_W]}})
                  opnd_in = excess_raw[SUM_W] ? EXC_MIN : EXC_MAX;
               else
                  opnd_in = excess_raw[OPND_W-1:0];
            end
            PH_WIND: begin
               if (wind_sh[PROD_W-1:DATA_W-1] != {(PROD_W-DATA_W+1){wind_sh[PROD_W-1]}})
                  wind_in = wind_sh[PROD_W-1] ? D_MIN : D_MAX;
               else
                  wind_in = wind_sh[DATA_W-1:0];
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      if (prop_sh[ACCP_W-1:DATA_W-1] != {(ACCP_W-DATA_W+1){prop_sh[ACCP_W-1]}})
         prop = prop_sh[ACCP_W-1] ? D_MIN : D_MAX;
      else
         prop = prop_sh[DATA_W-1:0];
   end

   assign integ = u_ff;

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      acc_p_ff <= acc_p_in;
      acc_i_ff <= acc_i_in;
      opnd_ff  <= opnd_in;
      u_ff     <= u_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         wind_ff <= '0;
      end else begin
         sum_ff  <= sum_in;
         wind_ff <= wind_in;
      end
   end

endmodule

// ===== rtl/sfia_merge.sv =====
module sfia_merge
   import sfia_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   output logic                     can_load,
   input  logic signed [DATA_W-1:0] prop [NLANE],
   input  logic signed [DATA_W-1:0] integ [NLANE],
   sfia_rsp_if.source               rsp
);

   logic                     valid_ff, valid_in;
   logic signed [DATA_W-1:0] prop_p_ff, prop_y_ff, integ_p_ff, integ_y_ff;

   assign can_load = !valid_ff || rsp.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load)
         valid_in = 1'b1;
      else if (rsp.ready)
         valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prop_p_ff  <= prop[0];
         prop_y_ff  <= prop[1];
         integ_p_ff <= integ[0];
         integ_y_ff <= integ[1];
      end
   end

   assign rsp.valid       = valid_ff;
   assign rsp.prop_pitch  = prop_p_ff;
   assign rsp.prop_yaw    = prop_y_ff;
   assign rsp.integ_pitch = integ_p_ff;
   assign rsp.integ_yaw   = integ_y_ff;

endmodule

// ===== rtl/state_feedback_integral_antiwindup.sv =====
// Two-axis state-feedback controller with integral action and back-calculation
// anti-windup. One beat on req_chan carries a sample (both angle errors and
// both angular speeds, Q16.16); one beat on rsp_chan returns the pitch and yaw
// proportional drives and the clamped integral drives. Pitch and yaw each run
// in their own lane with one 42x17 multiplier, walked through a fixed
// 14-step schedule. A new sample is accepted only while idle, so the block
// takes none until the last result is in the output register. A result
// waiting on rsp_chan holds the lanes until it is taken. Registers are
// written through csr_wr_en/csr_index/csr_wdata; the user must do so only
// while idle, which the block does not enforce. Unknown indexes are ignored.
module state_feedback_integral_antiwindup
   import sfia_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ROW_W-1:0]     csr_wdata,
   sfia_req_if.sink             req_chan,
   sfia_rsp_if.source           rsp_chan
);

   logic [ROW_W-1:0]   gains_pitch_ff, gains_yaw_ff, int_gains_ff;
   logic [TR_W-1:0]    inv_tr_p_ff, inv_tr_y_ff;
   logic [DRIVE_W-1:0] max_drive_ff;
   logic [DT_W-1:0]    step_dt_ff;

   state_type    state_ff, state_in;
   phase_type    phase_ff, phase_in;
   sample_type   x_ff;
   lane_ctl_type ctl;
   logic         load, can_load;

   logic signed [DATA_W-1:0] lane_prop  [NLANE];
   logic signed [DATA_W-1:0] lane_integ [NLANE];

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_pitch_ff <= GAINS_RESET;
         gains_yaw_ff   <= GAINS_RESET;
         int_gains_ff   <= GAINS_RESET;
         inv_tr_p_ff    <= INV_TR_RESET;
         inv_tr_y_ff    <= INV_TR_RESET;
         max_drive_ff   <= DRIVE_RESET;
         step_dt_ff     <= STEP_DT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_GAINS_PITCH: gains_pitch_ff <= csr_wdata;
            CSR_GAINS_YAW:   gains_yaw_ff   <= csr_wdata;
            CSR_INT_GAINS:   int_gains_ff   <= csr_wdata;
            CSR_INV_TR_P:    inv_tr_p_ff    <= csr_wdata[TR_W-1:0];
            CSR_INV_TR_Y:    inv_tr_y_ff    <= csr_wdata[TR_W-1:0];
            CSR_MAX_DRIVE:   max_drive_ff   <= csr_wdata[DRIVE_W-1:0];
            CSR_STEP_DT:     step_dt_ff     <= csr_wdata[DT_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_chan.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      load     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = ST_RUN;
               phase_in = PH_PROP0;
            end
         end
         ST_RUN: begin
            if (phase_ff == PH_WIND) begin
               if (can_load) begin
                  load     = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_HOLD;
               end
            end else begin
               phase_in = phase_type'(4'(phase_ff + 4'd1));
            end
         end
         ST_HOLD: begin
            if (can_load) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_PROP0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         x_ff.pitch_error <= req_chan.pitch_error;
         x_ff.yaw_error   <= req_chan.yaw_error;
         x_ff.pitch_rate  <= req_chan.pitch_rate;
         x_ff.yaw_rate    <= req_chan.yaw_rate;
      end
   end

   assign ctl.run   = (state_ff == ST_RUN);
   assign ctl.phase = phase_ff;

   sfia_lane u_lane_pitch (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .x         (x_ff),
      .row_gains (gains_pitch_ff),
      .int_gains (int_gains_ff[31:0]),
      .inv_tr    (inv_tr_p_ff),
      .max_drive (max_drive_ff),
      .step_dt   (step_dt_ff),
      .prop      (lane_prop[0]),
      .integ     (lane_integ[0])
   );

   sfia_lane u_lane_yaw (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .x         (x_ff),
      .row_gains (gains_yaw_ff),
      .int_gains (int_gains_ff[63:32]),
      .inv_tr    (inv_tr_y_ff),
      .max_drive (max_drive_ff),
      .step_dt   (step_dt_ff),
      .prop      (lane_prop[1]),
      .integ     (lane_integ[1])
   );

   sfia_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .can_load (can_load),
      .prop     (lane_prop),
      .integ    (lane_integ),
      .rsp      (rsp_chan)
   );

`ifndef NO_ASSERTIONS
   a_rsp_after_wind: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |->
         $past((state_ff == ST_RUN && phase_ff == PH_WIND) || state_ff == ST_HOLD))
      else $error("result raised outside lane completion");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (state_ff == ST_RUN && phase_ff == PH_PROP0))
      else $error("accepted beat did not start lanes");

   a_hold_blocked: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HOLD) |-> rsp_chan.valid)
      else $error("lanes held with empty output register");

   a_integ_in_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && phase_ff == PH_EXCESS) |->
         (lane_integ[0] <= $signed({1'b0, max_drive_ff}) &&
          lane_integ[0] >= -$signed({1'b0, max_drive_ff}) &&
          lane_integ[1] <= $signed({1'b0, max_drive_ff}) &&
          lane_integ[1] >= -$signed({1'b0, max_drive_ff})))
      else $error("integral drive outside clamp");
`endif

endmodule
